FILE: rtl/mdct_direct_sum_macros.svh
// ----------------------------------------------------------------------------
// MDCT assertion macros
// Shared concurrent assertion helpers for the MDCT block. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MDCT_DIRECT_SUM_MACROS_SVH
`define MDCT_DIRECT_SUM_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mds: same-cycle assertion failed");

// Next-cycle implication.
`define MDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mds: next-cycle assertion failed");

`else

`define MDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/mds_pkg.sv
// ----------------------------------------------------------------------------
// MDCT package
// Types shared by the MDCT controller and datapath, and fixed constants for the datapath.
// ----------------------------------------------------------------------------
package mds_pkg;

    // Accumulator width: up to 64 products of magnitude 2^30, plus rounding.
    localparam int ACC_W = 40;

    // Fixed-point constants for building the cosine table (Q2.30).
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // Taylor series divisors (2m-1)*(2m) for m = 1..12.
    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef enum logic [1:0] {
        S_LOAD,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic block_start;
        logic issue;
        logic emit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/mds_in_if.sv
// ----------------------------------------------------------------------------
// MDCT input channel
// Valid/ready channel carrying one sample and its window weight.
// ----------------------------------------------------------------------------
interface mds_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic signed [15:0] window_weight;

    modport source (output valid, output sample, output window_weight, input ready);
    modport sink   (input valid, input sample, input window_weight, output ready);
endinterface

FILE: rtl/mds_out_if.sv
// ----------------------------------------------------------------------------
// MDCT output channel
// Valid/ready channel carrying one coefficient, its index and a last flag.
// ----------------------------------------------------------------------------
interface mds_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coefficient;
    logic        [4:0]  coef_index;
    logic               last;

    modport source (output valid, output coefficient, output coef_index, output last,
                    input ready);
    modport sink   (input valid, input coefficient, input coef_index, input last,
                    output ready);
endinterface

FILE: rtl/mds_ctrl.sv
// ----------------------------------------------------------------------------
// MDCT controller
// Sequences sample loading, the multiply-accumulate sweep per coefficient
// and the hand-off of each coefficient to the output register.
// ----------------------------------------------------------------------------
`include "mdct_direct_sum_macros.svh"

module mds_ctrl #(
    parameter int HALF_LENGTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mds_pkg::t_dp_status              i_status,
    output mds_pkg::t_dp_cmd                 o_cmd,
    output logic [$clog2(2*HALF_LENGTH)-1:0] o_wr_addr,
    output logic [$clog2(2*HALF_LENGTH)-1:0] o_rd_addr,
    output logic [$clog2(HALF_LENGTH)-1:0]   o_k
);

    localparam int FULL = 2 * HALF_LENGTH;
    localparam int N_W  = $clog2(FULL);
    localparam int K_W  = $clog2(HALF_LENGTH);

    mds_pkg::t_state r_state, n_state;
    logic [N_W-1:0]  r_load_cnt, n_load_cnt;
    logic [N_W-1:0]  r_n, n_n;
    logic [K_W-1:0]  r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mds_pkg::S_LOAD;
            r_load_cnt <= '0;
            r_n        <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_n        <= n_n;
            r_k        <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_n        = r_n;
        n_k        = r_k;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mds_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_en = 1'b1;
                    if (r_load_cnt == N_W'(FULL - 1)) begin
                        n_load_cnt        = '0;
                        n_state           = mds_pkg::S_RUN;
                        o_cmd.block_start = 1'b1;
                    end else begin
                        n_load_cnt = r_load_cnt + N_W'(1);
                    end
                end
            end
            mds_pkg::S_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_n == N_W'(FULL - 1)) begin
                    n_n     = '0;
                    n_state = mds_pkg::S_DRAIN;
                end else begin
                    n_n = r_n + N_W'(1);
                end
            end
            mds_pkg::S_DRAIN: begin
                o_cmd.last = (r_k == K_W'(HALF_LENGTH - 1));
                // Wait for the last product to land in the accumulator and
                // for room in the output register.
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (o_cmd.last) begin
                        n_k     = '0;
                        n_state = mds_pkg::S_LOAD;
                    end else begin
                        n_k     = r_k + K_W'(1);
                        n_state = mds_pkg::S_RUN;
                    end
                end
            end
            default: begin
                n_state = mds_pkg::S_LOAD;
            end
        endcase
    end

    assign o_wr_addr = r_load_cnt;
    assign o_rd_addr = r_n;
    assign o_k       = r_k;

    `MDS_ASSERT_IMPLIES(a_emit_after_drain, i_clk, i_rst_n, o_cmd.emit, !i_status.pipe_busy)
    `MDS_ASSERT_NEXT(a_block_starts_run, i_clk, i_rst_n,
                     i_in_valid && o_in_ready && (r_load_cnt == N_W'(FULL - 1)),
                     r_state == mds_pkg::S_RUN)
    `MDS_ASSERT_IMPLIES(a_drain_sees_work, i_clk, i_rst_n,
                        (r_state == mds_pkg::S_DRAIN) && ($past(r_state) == mds_pkg::S_RUN),
                        i_status.pipe_busy)

endmodule

FILE: rtl/mds_dp.sv
// ----------------------------------------------------------------------------
// MDCT datapath
// Windowing multiplier, sample store, cosine table with modular index
// stepping, one pipelined multiply-accumulate unit and the output register.
// ----------------------------------------------------------------------------
`include "mdct_direct_sum_macros.svh"

module mds_dp #(
    parameter int HALF_LENGTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mds_pkg::t_dp_cmd                 i_cmd,
    output mds_pkg::t_dp_status              o_status,
    input  logic [$clog2(2*HALF_LENGTH)-1:0] i_wr_addr,
    input  logic [$clog2(2*HALF_LENGTH)-1:0] i_rd_addr,
    input  logic [$clog2(HALF_LENGTH)-1:0]   i_k,
    input  logic signed [15:0]               i_sample,
    input  logic signed [15:0]               i_window_weight,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic signed [31:0]               o_coefficient,
    output logic [4:0]                       o_coef_index,
    output logic                             o_last
);

    localparam int FULL     = 2 * HALF_LENGTH;
    localparam int ROM_SIZE = 8 * HALF_LENGTH;
    localparam int ROM_W    = $clog2(ROM_SIZE);
    localparam int ACC_W    = mds_pkg::ACC_W;

    // Cosine table entry i: round(32768 * cos(2*pi*i / (8N))), clamped.
    function automatic logic signed [15:0] cos_entry(input logic [ROM_W:0] idx);
        logic [63:0]        j;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic               neg;
        j   = 64'(idx);
        neg = 1'b0;
        if (j > 64'(4 * HALF_LENGTH)) begin
            j = 64'(ROM_SIZE) - j;
        end
        if (j > 64'(2 * HALF_LENGTH)) begin
            j   = 64'(4 * HALF_LENGTH) - j;
            neg = 1'b1;
        end
        x    = (mds_pkg::PI_Q30 * j + 64'(2 * HALF_LENGTH)) / 64'(4 * HALF_LENGTH);
        x2   = (x * x + (mds_pkg::ONE_Q30 >> 1)) >> 30;
        term = mds_pkg::ONE_Q30;
        sum  = signed'(mds_pkg::ONE_Q30);
        for (int m = 0; m < 12; m++) begin
            term = ((term * x2) >> 30) / mds_pkg::TAYLOR_DIV[m];
            if (m[0] == 1'b0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        mag = (unsigned'(sum) + 64'd16384) >> 15;
        if (mag > 64'd32768) begin
            mag = 64'd32768;
        end
        if (neg) begin
            return 16'(64'd0 - mag);
        end else if (mag > 64'd32767) begin
            return 16'sh7fff;
        end else begin
            return 16'(mag);
        end
    endfunction

    logic signed [15:0] cos_tbl [ROM_SIZE];

    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_cos_rom
        assign cos_tbl[g] = cos_entry((ROM_W + 1)'(g));
    end

    // Windowing: Q2.30 product rounded to Q1.15, positive overflow saturates.
    logic signed [31:0] win_prod;
    logic signed [31:0] win_shift;
    logic signed [15:0] win_val;

    assign win_prod  = 32'(i_sample) * 32'(i_window_weight);
    assign win_shift = (win_prod + 32'sd16384) >>> 15;
    assign win_val   = (win_shift > 32'sd32767) ? 16'sh7fff : win_shift[15:0];

    logic signed [15:0] r_store [FULL];
    logic signed [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_store[i_wr_addr] <= win_val;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_store[i_rd_addr];
        end
    end

    // Cosine index: (2n+1+N)(2k+1) mod 8N, stepped by 2(2k+1) along n and
    // by 2N+2 along k, each wrapped with one compare and subtract.
    logic [ROM_W-1:0] r_idx;
    logic [ROM_W-1:0] r_base;
    logic [ROM_W-1:0] r_step;
    logic [ROM_W:0]   idx_sum;
    logic [ROM_W:0]   base_sum;
    logic [ROM_W-1:0] idx_next;
    logic [ROM_W-1:0] base_next;

    assign idx_sum   = {1'b0, r_idx} + {1'b0, r_step};
    assign idx_next  = (idx_sum >= (ROM_W + 1)'(ROM_SIZE))
                     ? ROM_W'(idx_sum - (ROM_W + 1)'(ROM_SIZE)) : idx_sum[ROM_W-1:0];
    assign base_sum  = {1'b0, r_base} + (ROM_W + 1)'(2 * HALF_LENGTH + 2);
    assign base_next = (base_sum >= (ROM_W + 1)'(ROM_SIZE))
                     ? ROM_W'(base_sum - (ROM_W + 1)'(ROM_SIZE)) : base_sum[ROM_W-1:0];

    logic signed [15:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.block_start) begin
            r_base <= ROM_W'(HALF_LENGTH + 1);
            r_idx  <= ROM_W'(HALF_LENGTH + 1);
            r_step <= ROM_W'(2);
        end else if (i_cmd.emit) begin
            r_base <= base_next;
            r_idx  <= base_next;
            r_step <= r_step + ROM_W'(4);
        end else if (i_cmd.issue) begin
            r_idx <= idx_next;
        end
        if (i_cmd.issue) begin
            r_cos <= cos_tbl[r_idx];
        end
    end

    // Multiply-accumulate pipeline: operand read, product, accumulate.
    logic                    r_v1;
    logic                    r_v2;
    logic signed [31:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      mac_prod;
    logic signed [ACC_W-1:0] acc_rnd;

    assign mac_prod = 32'(r_rd_data) * 32'(r_cos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= mac_prod;
        end
        if (i_cmd.block_start || i_cmd.emit) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round the Q10.30 sum once to Q25.15; the output keeps its low 32 bits (Q17.15).
    assign acc_rnd = (r_acc + ACC_W'(16384)) >>> 15;

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_coefficient <= acc_rnd[31:0];
            o_coef_index  <= 5'(i_k);
            o_last        <= i_cmd.last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.pipe_busy = r_v1 | r_v2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    `MDS_ASSERT_IMPLIES(a_idx_in_range, i_clk, i_rst_n, i_cmd.issue,
                        r_idx <= ROM_W'(ROM_SIZE - 1))
    `MDS_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !i_cmd.emit)
    `MDS_ASSERT_NEXT(a_emit_loads_output, i_clk, i_rst_n, i_cmd.emit, r_out_valid)

endmodule

FILE: rtl/mdct_direct_sum.sv
// ----------------------------------------------------------------------------
// MDCT direct-sum transform, 2N samples in, N coefficients out
// Loading takes one cycle per sample; after the 2N-th sample each
// coefficient is summed in turn on the single multiply-accumulate unit.
// No new sample is accepted until the block's last coefficient is emitted.
// Reset (synchronous, active low) clears control; the store is not cleared.
// ----------------------------------------------------------------------------
module mdct_direct_sum #(
    parameter int HALF_LENGTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mds_in_if.sink     i_in,
    mds_out_if.source  o_res
);

    localparam int N_W = $clog2(2 * HALF_LENGTH);
    localparam int K_W = $clog2(HALF_LENGTH);

    mds_pkg::t_dp_cmd    dp_cmd;
    mds_pkg::t_dp_status dp_status;
    logic [N_W-1:0]      wr_addr;
    logic [N_W-1:0]      rd_addr;
    logic [K_W-1:0]      coef_k;
    logic                in_ready;

    mds_ctrl #(
        .HALF_LENGTH(HALF_LENGTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_k        (coef_k)
    );

    mds_dp #(
        .HALF_LENGTH(HALF_LENGTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_wr_addr       (wr_addr),
        .i_rd_addr       (rd_addr),
        .i_k             (coef_k),
        .i_sample        (i_in.sample),
        .i_window_weight (i_in.window_weight),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_coefficient   (o_res.coefficient),
        .o_coef_index    (o_res.coef_index),
        .o_last          (o_res.last)
    );

    assign i_in.ready = in_ready;

endmodule
